/* design/sshl_pkg.sv */
// Package for the shader slot hash and length block.
// Holds the hash constants, queue sizing and the queue entry type.
// No dependencies; every other file but sshl_if imports it.
package sshl_pkg;

   // FNV-1a 64-bit offset basis; the prime is applied as a shift-add in the back end.
   localparam logic [63:0] HashBasis = 64'hCBF29CE484222325;

   // Source-word bits 9:8 with this code mark a reference to inline constant data.
   localparam logic [1:0] ConstSrcCode = 2'b10;
   localparam int SrcSelLsb = 8;

   // Bit of word0 that ends a program.
   localparam int EndBit = 8;

   // Queue between the front and back ends.
   localparam int QueueDepth      = 2;
   localparam int QueuePtrWidth   = $clog2(QueueDepth);
   localparam int QueueCountWidth = $clog2(QueueDepth + 1);

   // One classified instruction slot on its way to the back end.
   typedef struct packed {
      logic [63:0] slot_low;
      logic [63:0] slot_high;
      logic        has_const;
      logic        last;
   } slot_entry_type;

endpackage

/* design/sshl_if.sv */
// Channel interfaces for the shader slot hash and length block.
// Each carries valid, ready and the payload; no package dependencies.

// Slot input channel.
interface sshl_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] slot_low;
   logic [63:0] slot_high;

   modport source (output valid, output slot_low, output slot_high, input ready);
   modport sink (input valid, input slot_low, input slot_high, output ready);
endinterface

// Program result channel.
interface sshl_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] program_hash;
   logic [13:0] ucode_bytes;
   logic        length_overflow;

   modport source (output valid, output program_hash, output ucode_bytes,
                   output length_overflow, input ready);
   modport sink (input valid, input program_hash, input ucode_bytes,
                 input length_overflow, output ready);
endinterface

/* design/sshl_fifo.sv */
// Short queue of classified slots between the front and back ends.
// Depends on sshl_pkg for the entry type and queue sizing.
module sshl_fifo import sshl_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  slot_entry_type push_entry,
   output logic           full,
   input  logic           pop,
   output slot_entry_type head_entry,
   output logic           empty
);

   slot_entry_type             entry_ff [QueueDepth];
   logic [QueuePtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueueCountWidth-1:0] fill_ff, fill_in;
   logic                       do_push, do_pop;

   assign full       = (fill_ff == QueueCountWidth'(QueueDepth));
   assign empty      = (fill_ff == '0);
   assign head_entry = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && !empty;

   // Pointer and fill update; pointers wrap at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QueuePtrWidth'(QueueDepth - 1)) ? '0
                   : wr_ptr_ff + QueuePtrWidth'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QueuePtrWidth'(QueueDepth - 1)) ? '0
                   : rd_ptr_ff + QueuePtrWidth'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + QueueCountWidth'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - QueueCountWidth'(1);
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

/* design/sshl_front.sv */
// Front end: accepts slots, drops inline constant data slots and classifies
// instruction slots for the back end. Depends on sshl_pkg and sshl_if.
module sshl_front import sshl_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   sshl_req_if.sink       req_chan,
   input  logic           queue_full,
   output logic           push,
   output slot_entry_type push_entry
);

   logic skip_ff, skip_in;
   logic accept;
   logic has_const;

   // A source word references a constant when its bits 9:8 hold the constant code.
   function automatic logic refs_constant(input logic [31:0] word);
      return word[SrcSelLsb +: 2] == ConstSrcCode;
   endfunction

   assign has_const = refs_constant(req_chan.slot_low[63:32])
                   || refs_constant(req_chan.slot_high[31:0])
                   || refs_constant(req_chan.slot_high[63:32]);

   // A constant data slot is dropped here, so it needs no queue space.
   assign req_chan.ready = skip_ff || !queue_full;
   assign accept         = req_chan.valid && req_chan.ready;
   assign push           = accept && !skip_ff;

   assign push_entry.slot_low  = req_chan.slot_low;
   assign push_entry.slot_high = req_chan.slot_high;
   assign push_entry.has_const = has_const;
   assign push_entry.last      = req_chan.slot_low[EndBit];

   // The slot after a constant-referencing instruction is data.
   always_comb begin
      skip_in = skip_ff;
      if (accept) begin
         skip_in = skip_ff ? 1'b0 : has_const;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff <= 1'b0;
      end else begin
         skip_ff <= skip_in;
      end
   end

endmodule

/* design/sshl_back.sv */
// Back end: folds each instruction slot into the running hash, one half per
// cycle unless an end slot waits on an untaken result, keeps the slot count and
// registers the program result. Depends on sshl_pkg and sshl_if.
module sshl_back import sshl_pkg::*; #(
   parameter int MAX_SLOTS = 512
) (
   input  logic           clock,
   input  logic           reset,
   input  slot_entry_type head_entry,
   input  logic           queue_empty,
   output logic           pop,
   sshl_rsp_if.source     rsp_chan
);

   localparam int CountWidth = $clog2(MAX_SLOTS + 1);
   localparam logic [CountWidth:0] MaxSlotsWide = (CountWidth + 1)'(MAX_SLOTS);

   typedef enum logic {
      PH_LOW,
      PH_HIGH
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [63:0]           hash_ff, hash_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  sat_ff, sat_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [63:0]           rsp_hash_ff, rsp_hash_in;
   logic [13:0]           rsp_bytes_ff, rsp_bytes_in;
   logic                  rsp_ovf_ff, rsp_ovf_in;

   logic [63:0]            mix_data;
   logic [63:0]            mix_x;
   logic [63:0]            mixed;
   logic [CountWidth:0]    sum;
   logic                   over;
   logic [CountWidth-1:0]  next_count;
   logic [CountWidth+17:0] bytes_wide;
   logic                   out_blocked;

   // One FNV-1a step: xor in the data, then multiply by 2^40 + 0x1B3 as a shift-add.
   assign mix_data = (phase_ff == PH_LOW) ? head_entry.slot_low : head_entry.slot_high;
   assign mix_x    = hash_ff ^ mix_data;
   assign mixed    = (mix_x << 40) + (mix_x << 8) + (mix_x << 7) + (mix_x << 5)
                   + (mix_x << 4) + (mix_x << 1) + mix_x;

   // Saturating slot count; a constant reference counts its data slot too.
   assign sum        = {1'b0, count_ff}
                     + (head_entry.has_const ? (CountWidth + 1)'(2) : (CountWidth + 1)'(1));
   assign over       = sum > MaxSlotsWide;
   assign next_count = over ? MaxSlotsWide[CountWidth-1:0] : sum[CountWidth-1:0];
   assign bytes_wide = {14'b0, next_count, 4'b0000};

   // An end slot waits while the result register still holds an untaken result.
   assign out_blocked = head_entry.last && rsp_valid_ff && !rsp_chan.ready;

   always_comb begin
      phase_in     = phase_ff;
      hash_in      = hash_ff;
      count_in     = count_ff;
      sat_in       = sat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_hash_in  = rsp_hash_ff;
      rsp_bytes_in = rsp_bytes_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      pop          = 1'b0;
      unique case (phase_ff)
         PH_LOW: begin
            if (!queue_empty) begin
               hash_in  = mixed;
               phase_in = PH_HIGH;
            end
         end
         PH_HIGH: begin
            if (!out_blocked) begin
               pop      = 1'b1;
               phase_in = PH_LOW;
               if (head_entry.last) begin
                  rsp_valid_in = 1'b1;
                  rsp_hash_in  = mixed;
                  rsp_bytes_in = bytes_wide[13:0];
                  rsp_ovf_in   = sat_ff || over;
                  hash_in      = HashBasis;
                  count_in     = '0;
                  sat_in       = 1'b0;
               end else begin
                  hash_in  = mixed;
                  count_in = next_count;
                  sat_in   = sat_ff || over;
               end
            end
         end
         default: begin
            phase_in = PH_LOW;
         end
      endcase
   end

   // State and registered result; the result payload needs no reset.
   always_ff @(posedge clock) begin
      rsp_hash_ff  <= rsp_hash_in;
      rsp_bytes_ff <= rsp_bytes_in;
      rsp_ovf_ff   <= rsp_ovf_in;
      if (reset) begin
         phase_ff     <= PH_LOW;
         hash_ff      <= HashBasis;
         count_ff     <= '0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         hash_ff      <= hash_in;
         count_ff     <= count_in;
         sat_ff       <= sat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.program_hash    = rsp_hash_ff;
   assign rsp_chan.ucode_bytes     = rsp_bytes_ff;
   assign rsp_chan.length_overflow = rsp_ovf_ff;

endmodule

/* design/shader_slot_hash_and_length.sv */
// Channel    Direction  Payload
// req_chan   in         slot_low[63:0], slot_high[63:0]
// rsp_chan   out        program_hash[63:0], ucode_bytes[13:0], length_overflow
//
// An instruction slot takes two 64-bit hash steps in the back end, one per cycle unless an end slot stalls;
// a constant data slot is dropped by the front end and costs no back-end time.
// A result appears in the output register the cycle after the end slot's second step.
// Reset is synchronous and restores the offset basis and zero counts at once.
// A two-entry queue lets the front accept slots while the back end hashes or waits
// on an untaken result; the back end stalls only on an end slot with the output full.
//
// Top level: front end, slot queue, back end. Depends on sshl_pkg and sshl_if.
module shader_slot_hash_and_length import sshl_pkg::*; #(
   parameter int MAX_SLOTS = 512
) (
   input logic        clock,
   input logic        reset,
   sshl_req_if.sink   req_chan,
   sshl_rsp_if.source rsp_chan
);

   slot_entry_type push_entry;
   slot_entry_type head_entry;
   logic           push;
   logic           pop;
   logic           queue_full;
   logic           queue_empty;

   // Accept and classify slots.
   sshl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   // Decouple the front from the hash engine.
   sshl_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_entry (head_entry),
      .empty      (queue_empty)
   );

   // Hash, count and deliver results.
   sshl_back #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head_entry  (head_entry),
      .queue_empty (queue_empty),
      .pop         (pop),
      .rsp_chan    (rsp_chan)
   );

endmodule
